>>> hdl/hemisphere_partition_min_mass_macros.svh
// Assertion macros for the hemisphere partition block.
`ifndef HEMISPHERE_PARTITION_MIN_MASS_MACROS_SVH
`define HEMISPHERE_PARTITION_MIN_MASS_MACROS_SVH
`ifndef SYNTH
`define HPMM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpmm: implication check failed");
`define HPMM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpmm: next-cycle check failed");
`else
`define HPMM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HPMM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/hpmm_pkg.sv
// Types and constants shared by the hemisphere partition block.
package hpmm_pkg;

    localparam int DEF_MAX_JETS      = 12;
    localparam int DEF_MOMENTUM_BITS = 18;

    localparam int OUT_W  = 22;
    localparam int USED_W = 4;

    localparam int NUM_COMP = 4;
    localparam int COMP_E   = 0;
    localparam int COMP_PX  = 1;
    localparam int COMP_PY  = 2;
    localparam int COMP_PZ  = 3;

    localparam int NUM_TERMS = 4;
    localparam int TERM_W    = 2;
    localparam logic [TERM_W-1:0] TERM_FIRST = TERM_W'(0);
    localparam logic [TERM_W-1:0] TERM_LAST  = TERM_W'(NUM_TERMS - 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_UPD,
        S_MUL,
        S_WAIT,
        S_CMP,
        S_SEL
    } t_state;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic neg;
    } t_mac_ctrl;

endpackage

>>> hdl/hpmm_mac.sv
// Shared signed multiply-accumulate unit with one registered product stage.
module hpmm_mac #(
    parameter int SUM_W = hpmm_pkg::DEF_MOMENTUM_BITS + $clog2(hpmm_pkg::DEF_MAX_JETS) + 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  hpmm_pkg::t_mac_ctrl       i_ctrl,
    input  logic signed [SUM_W-1:0]   i_op_a,
    input  logic signed [SUM_W-1:0]   i_op_b,
    output logic signed [2*SUM_W+1:0] o_acc
);
    import hpmm_pkg::*;

    localparam int PROD_W = 2 * SUM_W;
    localparam int ACC_W  = PROD_W + 2;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_neg;
    logic                     r_pend;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_prod_ext;

    assign w_prod_ext = {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign o_acc      = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_ctrl.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_op_a * i_op_b;
            r_neg  <= i_ctrl.neg;
        end
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (r_pend) begin
            r_acc <= r_neg ? (r_acc - w_prod_ext) : (r_acc + w_prod_ext);
        end
    end

endmodule

>>> hdl/hemisphere_partition_min_mass.sv
// Top level: jet store, split sequencer and hemisphere selection.
// Load: one cycle per jet, back to back; the jet with the last flag ends the load and, with
// two jets or more, starts the search: each split i in 1..2^n-2 takes update steps that move
// the changed jets between the sides, then 4 products on the shared multiplier, a drain and
// a compare. A pt compare then picks the lead side; when the output is free, o_valid rises,
// the result loads and the input is freed. Reset: synchronous, active low; store not cleared.
module hemisphere_partition_min_mass #(
    parameter int MAX_JETS      = hpmm_pkg::DEF_MAX_JETS,
    parameter int MOMENTUM_BITS = hpmm_pkg::DEF_MOMENTUM_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [MOMENTUM_BITS-1:0]    i_jet_px,
    input  logic signed [MOMENTUM_BITS-1:0]    i_jet_py,
    input  logic signed [MOMENTUM_BITS-1:0]    i_jet_pz,
    input  logic        [MOMENTUM_BITS-1:0]    i_jet_energy,
    input  logic                               i_last_jet,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [hpmm_pkg::OUT_W-1:0]  o_lead_px,
    output logic signed [hpmm_pkg::OUT_W-1:0]  o_lead_py,
    output logic signed [hpmm_pkg::OUT_W-1:0]  o_lead_pz,
    output logic        [hpmm_pkg::OUT_W-1:0]  o_lead_energy,
    output logic signed [hpmm_pkg::OUT_W-1:0]  o_trail_px,
    output logic signed [hpmm_pkg::OUT_W-1:0]  o_trail_py,
    output logic signed [hpmm_pkg::OUT_W-1:0]  o_trail_pz,
    output logic        [hpmm_pkg::OUT_W-1:0]  o_trail_energy,
    output logic        [hpmm_pkg::USED_W-1:0] o_jets_used,
    output logic                               o_jets_dropped
);
    import hpmm_pkg::*;
`include "hemisphere_partition_min_mass_macros.svh"

    localparam int MB    = MOMENTUM_BITS;
    localparam int IDX_W = $clog2(MAX_JETS);
    localparam int CNT_W = $clog2(MAX_JETS + 1);
    localparam int SUM_W = MB + IDX_W + 1;
    localparam int ACC_W = 2 * SUM_W + 2;
    localparam int EXT_W = ((SUM_W > OUT_W) ? SUM_W : OUT_W) + 1;

    localparam logic signed [EXT_W-1:0] SHI = {{(EXT_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
    localparam logic signed [EXT_W-1:0] SLO = ~SHI;
    localparam logic signed [EXT_W-1:0] UHI = {{(EXT_W - OUT_W){1'b0}}, {OUT_W{1'b1}}};

    function automatic logic signed [SUM_W-1:0] f_ext(input logic [MB-1:0] raw,
                                                       input logic is_signed);
        f_ext = {{(SUM_W - MB){is_signed & raw[MB-1]}}, raw};
    endfunction

    function automatic logic [OUT_W-1:0] f_sat(input logic signed [SUM_W-1:0] v,
                                               input logic is_unsigned);
        logic signed [EXT_W-1:0] x;
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] lo;
        x  = {{(EXT_W - SUM_W){v[SUM_W-1]}}, v};
        hi = is_unsigned ? UHI : SHI;
        lo = is_unsigned ? '0 : SLO;
        if (x > hi) begin
            x = hi;
        end else if (x < lo) begin
            x = lo;
        end
        f_sat = x[OUT_W-1:0];
    endfunction

    t_state                  r_state, n_state;
    logic [MB-1:0]           r_store [NUM_COMP][MAX_JETS];
    logic [CNT_W-1:0]        r_jet_count;
    logic                    r_overflow;
    logic signed [SUM_W-1:0] r_total  [NUM_COMP];
    logic signed [SUM_W-1:0] r_a      [NUM_COMP];
    logic signed [SUM_W-1:0] r_b      [NUM_COMP];
    logic signed [SUM_W-1:0] r_best_a [NUM_COMP];
    logic signed [SUM_W-1:0] r_best_b [NUM_COMP];
    logic signed [ACC_W-1:0] r_best_d;
    logic                    r_have;
    logic [MAX_JETS-1:0]     r_idx;
    logic [IDX_W-1:0]        r_bit;
    logic [TERM_W-1:0]       r_term;
    logic                    r_pt_mode;
    logic [OUT_W-1:0]        r_lead  [NUM_COMP];
    logic [OUT_W-1:0]        r_trail [NUM_COMP];
    logic                    r_out_valid;
    logic [USED_W-1:0]       r_out_used;
    logic                    r_out_dropped;

    logic [MB-1:0]           w_in      [NUM_COMP];
    logic signed [SUM_W-1:0] w_in_ext  [NUM_COMP];
    logic signed [SUM_W-1:0] w_tot_nxt [NUM_COMP];
    logic signed [SUM_W-1:0] w_jet     [NUM_COMP];
    logic                    w_accept;
    logic                    w_room;
    logic [CNT_W-1:0]        w_cnt_next;
    logic [CNT_W-1:0]        w_k;
    logic                    w_bit_set;
    logic [MAX_JETS-1:0]     w_idx_next;
    logic [MAX_JETS:0]       w_full;
    logic                    w_done;
    logic [TERM_W-1:0]       w_pt_comp;
    logic signed [SUM_W-1:0] w_op_a;
    logic signed [SUM_W-1:0] w_op_b;
    logic                    w_neg;
    t_mac_ctrl               w_ctrl;
    logic signed [ACC_W-1:0] w_acc;
    logic                    w_acc_pos;
    logic [CNT_W+USED_W-1:0] w_used_ext;
    logic                    w_out_free;

    assign w_in[COMP_E]  = i_jet_energy;
    assign w_in[COMP_PX] = i_jet_px;
    assign w_in[COMP_PY] = i_jet_py;
    assign w_in[COMP_PZ] = i_jet_pz;

    always_comb begin
        for (int c = 0; c < NUM_COMP; c++) begin
            w_in_ext[c]  = f_ext(w_in[c], c != COMP_E);
            w_tot_nxt[c] = w_room ? (r_total[c] + w_in_ext[c]) : r_total[c];
            w_jet[c]     = f_ext(r_store[c][w_k[IDX_W-1:0]], c != COMP_E);
        end
    end

    assign w_accept   = (r_state == S_LOAD) && i_valid;
    assign w_room     = r_jet_count < CNT_W'(MAX_JETS);
    assign w_cnt_next = w_room ? (r_jet_count + CNT_W'(1)) : r_jet_count;
    assign w_k        = r_jet_count - CNT_W'(1) - CNT_W'(r_bit);
    assign w_bit_set  = r_idx[r_bit];
    assign w_full     = ({{MAX_JETS{1'b0}}, 1'b1} << r_jet_count) - 1'b1;
    assign w_done     = w_idx_next == w_full[MAX_JETS-1:0];
    assign w_acc_pos  = !w_acc[ACC_W-1] && (w_acc != '0);
    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        w_idx_next        = r_idx;
        w_idx_next[r_bit] = ~w_bit_set;
    end

    always_comb begin
        w_pt_comp = r_term[0] ? TERM_W'(COMP_PY) : TERM_W'(COMP_PX);
        if (r_pt_mode) begin
            w_op_a = r_term[1] ? r_best_b[w_pt_comp] : r_best_a[w_pt_comp];
            w_op_b = w_op_a;
            w_neg  = r_term[1];
        end else begin
            w_op_a = r_a[r_term];
            w_op_b = r_b[r_term];
            w_neg  = r_term != TERM_W'(COMP_E);
        end
    end

    hpmm_mac #(
        .SUM_W (SUM_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_op_a  (w_op_a),
        .i_op_b  (w_op_b),
        .o_acc   (w_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        w_ctrl  = '0;
        case (r_state)
            S_LOAD: begin
                o_stall = 1'b0;
                if (i_valid && i_last_jet) begin
                    n_state = (w_cnt_next >= CNT_W'(2)) ? S_UPD : S_MUL;
                end
            end
            S_UPD: begin
                if (!w_bit_set) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                w_ctrl.mul_en = 1'b1;
                w_ctrl.clear  = r_term == TERM_FIRST;
                w_ctrl.neg    = w_neg;
                if (r_term == TERM_LAST) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = r_pt_mode ? S_SEL : S_CMP;
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_SEL: begin
                if (w_out_free) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_room) begin
            for (int c = 0; c < NUM_COMP; c++) begin
                r_store[c][r_jet_count[IDX_W-1:0]] <= w_in[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_SEL) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jet_count <= '0;
            r_overflow  <= 1'b0;
            r_have      <= 1'b0;
            r_pt_mode   <= 1'b0;
            r_term      <= TERM_FIRST;
            r_bit       <= '0;
            r_idx       <= '0;
            r_total     <= '{default: '0};
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (w_room) begin
                            r_jet_count <= w_cnt_next;
                            r_total     <= w_tot_nxt;
                        end else begin
                            r_overflow <= 1'b1;
                        end
                        if (i_last_jet) begin
                            r_a       <= '{default: '0};
                            r_b       <= w_tot_nxt;
                            r_best_a  <= '{default: '0};
                            r_best_b  <= '{default: '0};
                            r_idx     <= '0;
                            r_bit     <= '0;
                            r_have    <= 1'b0;
                            r_term    <= TERM_FIRST;
                            r_pt_mode <= w_cnt_next < CNT_W'(2);
                        end
                    end
                end
                S_UPD: begin
                    for (int c = 0; c < NUM_COMP; c++) begin
                        if (w_bit_set) begin
                            r_a[c] <= r_a[c] - w_jet[c];
                            r_b[c] <= r_b[c] + w_jet[c];
                        end else begin
                            r_a[c] <= r_a[c] + w_jet[c];
                            r_b[c] <= r_b[c] - w_jet[c];
                        end
                    end
                    r_idx <= w_idx_next;
                    r_bit <= w_bit_set ? (r_bit + IDX_W'(1)) : '0;
                    if (!w_bit_set && w_done) begin
                        r_pt_mode <= 1'b1;
                    end
                end
                S_MUL: begin
                    r_term <= r_term + TERM_W'(1);
                end
                S_CMP: begin
                    if (!r_have || (w_acc > r_best_d)) begin
                        r_have   <= 1'b1;
                        r_best_d <= w_acc;
                        r_best_a <= r_a;
                        r_best_b <= r_b;
                    end
                end
                S_SEL: begin
                    if (w_out_free) begin
                        for (int c = 0; c < NUM_COMP; c++) begin
                            r_lead[c]  <= f_sat(w_acc_pos ? r_best_a[c] : r_best_b[c],
                                                c == COMP_E);
                            r_trail[c] <= f_sat(w_acc_pos ? r_best_b[c] : r_best_a[c],
                                                c == COMP_E);
                        end
                        r_out_used    <= w_used_ext[USED_W-1:0];
                        r_out_dropped <= r_overflow;
                        r_jet_count   <= '0;
                        r_overflow    <= 1'b0;
                        r_total       <= '{default: '0};
                    end
                end
                default: begin
                    r_term <= TERM_FIRST;
                end
            endcase
        end
    end

    assign w_used_ext     = {{USED_W{1'b0}}, r_jet_count};
    assign o_valid        = r_out_valid;
    assign o_lead_px      = r_lead[COMP_PX];
    assign o_lead_py      = r_lead[COMP_PY];
    assign o_lead_pz      = r_lead[COMP_PZ];
    assign o_lead_energy  = r_lead[COMP_E];
    assign o_trail_px     = r_trail[COMP_PX];
    assign o_trail_py     = r_trail[COMP_PY];
    assign o_trail_pz     = r_trail[COMP_PZ];
    assign o_trail_energy = r_trail[COMP_E];
    assign o_jets_used    = r_out_used;
    assign o_jets_dropped = r_out_dropped;

    `HPMM_ASSERT_IMP(a_scan_in_range, i_clk, i_rst_n, r_state == S_UPD, CNT_W'(r_bit) < r_jet_count)
    `HPMM_ASSERT_IMP(a_split_needs_two, i_clk, i_rst_n, r_state == S_CMP, r_jet_count >= CNT_W'(2))
    `HPMM_ASSERT_IMP(a_count_capped, i_clk, i_rst_n, r_state == S_LOAD, r_jet_count <= CNT_W'(MAX_JETS))
    `HPMM_ASSERT_NXT(a_event_end, i_clk, i_rst_n, (r_state == S_SEL) && w_out_free, (r_state == S_LOAD) && (r_jet_count == '0) && !r_overflow && o_valid)
    `HPMM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_lead_energy) && $stable(o_trail_px))

endmodule

>>> verif/hpmm_split_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the hemisphere partition block: least-mass split predictor and result checks.
package hpmm_split_pkg;
    import hpmm_pkg::*;

    localparam int JET_CAP    = DEF_MAX_JETS;
    localparam int MOM_W      = DEF_MOMENTUM_BITS;
    localparam int NUM_FIELDS = 2 * NUM_COMP;
    localparam int MAX_PRINTS = 40;

    typedef logic [NUM_COMP-1:0][OUT_W-1:0] t_fields;

    typedef struct {
        longint px;
        longint py;
        longint pz;
        longint e;
    } t_hemi;

    typedef struct packed {
        logic [NUM_FIELDS-1:0][OUT_W-1:0] comp;
        logic [USED_W-1:0]                used;
        logic                             dropped;
    } t_split;

    class split_tracker;
        longint      jet_px [JET_CAP];
        longint      jet_py [JET_CAP];
        longint      jet_pz [JET_CAP];
        longint      jet_e  [JET_CAP];
        int          stored;
        bit          overflow;
        t_split      awaited_splits [$];
        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned events;
        int unsigned dropped_events;
        int          largest;

        function new();
            stored = 0;
            overflow = 1'b0;
            mismatches = 0;
            results_seen = 0;
            events = 0;
            dropped_events = 0;
            largest = 0;
        endfunction

        function logic [OUT_W-1:0] clip_signed(longint v);
            longint lim;
            lim = (longint'(1) << (OUT_W - 1)) - 1;
            if (v > lim) v = lim;
            if (v < -lim - 1) v = -lim - 1;
            return v[OUT_W-1:0];
        endfunction

        function logic [OUT_W-1:0] clip_unsigned(longint v);
            longint lim;
            lim = (longint'(1) << OUT_W) - 1;
            if (v > lim) v = lim;
            if (v < 0) v = 0;
            return v[OUT_W-1:0];
        endfunction

        function t_fields hemi_fields(t_hemi h);
            t_fields f;
            f[COMP_E]  = clip_unsigned(h.e);
            f[COMP_PX] = clip_signed(h.px);
            f[COMP_PY] = clip_signed(h.py);
            f[COMP_PZ] = clip_signed(h.pz);
            return f;
        endfunction

        function longint mass2(t_hemi h);
            return h.e * h.e - h.px * h.px - h.py * h.py - h.pz * h.pz;
        endfunction

        function longint pt2(t_hemi h);
            return h.px * h.px + h.py * h.py;
        endfunction

        function t_hemi add_jet(t_hemi h, int k);
            h.px += jet_px[k];
            h.py += jet_py[k];
            h.pz += jet_pz[k];
            h.e  += jet_e[k];
            return h;
        endfunction

        // Exhaustive search over every non-trivial split; earliest index wins ties.
        function t_split least_mass_split();
            t_hemi  a, b, best_a, best_b, lead, trail;
            longint m, best_m;
            bit     have;
            t_split s;
            best_a = '{0, 0, 0, 0};
            best_b = '{0, 0, 0, 0};
            best_m = 0;
            have = 1'b0;
            if (stored >= 2) begin
                for (int idx = 1; idx < (1 << stored) - 1; idx++) begin
                    a = '{0, 0, 0, 0};
                    b = '{0, 0, 0, 0};
                    for (int k = 0; k < stored; k++) begin
                        if (idx[stored - 1 - k]) a = add_jet(a, k);
                        else b = add_jet(b, k);
                    end
                    m = mass2(a) + mass2(b);
                    if (!have || m < best_m) begin
                        have = 1'b1;
                        best_m = m;
                        best_a = a;
                        best_b = b;
                    end
                end
            end
            // hemisphere two leads on a pt tie
            if (pt2(best_a) > pt2(best_b)) begin
                lead = best_a;
                trail = best_b;
            end else begin
                lead = best_b;
                trail = best_a;
            end
            s.comp = {hemi_fields(trail), hemi_fields(lead)};
            s.used = stored[USED_W-1:0];
            s.dropped = overflow;
            return s;
        endfunction

        function void absorb_jet(input logic signed [MOM_W-1:0] px, py, pz,
                                 input logic [MOM_W-1:0] e, input logic last);
            if (stored < JET_CAP) begin
                jet_px[stored] = px;
                jet_py[stored] = py;
                jet_pz[stored] = pz;
                jet_e[stored]  = e;
                stored++;
            end else begin
                overflow = 1'b1;
            end
            if (last) begin
                awaited_splits = {awaited_splits, least_mass_split()};
                events++;
                if (overflow) dropped_events++;
                if (stored > largest) largest = stored;
                stored = 0;
                overflow = 1'b0;
            end
        endfunction

        function string comp_name(int i);
            string side, part;
            side = (i < NUM_COMP) ? "lead" : "trail";
            case (i % NUM_COMP)
                COMP_E:  part = "energy";
                COMP_PX: part = "px";
                COMP_PY: part = "py";
                default: part = "pz";
            endcase
            return {side, "_", part};
        endfunction

        function longint field_value(int i, logic [OUT_W-1:0] v);
            if ((i % NUM_COMP) == COMP_E) return longint'(v);
            return longint'($signed(v));
        endfunction

        task report_mismatch(string what, longint got, longint want);
            if (mismatches < MAX_PRINTS)
                $display("mismatch on %s: got %0d, expected %0d (result %0d)",
                         what, got, want, results_seen);
            mismatches++;
        endtask

        task compare_result(t_split got);
            t_split want;
            results_seen++;
            if (awaited_splits.size() == 0) begin
                report_mismatch("result with no event pending", 1, 0);
                return;
            end
            want = awaited_splits.pop_front();
            for (int i = 0; i < NUM_FIELDS; i++) begin
                if (got.comp[i] !== want.comp[i])
                    report_mismatch(comp_name(i), field_value(i, got.comp[i]),
                                    field_value(i, want.comp[i]));
            end
            if (got.used !== want.used)
                report_mismatch("jets_used", longint'(got.used), longint'(want.used));
            if (got.dropped !== want.dropped)
                report_mismatch("jets_dropped", longint'(got.dropped), longint'(want.dropped));
        endtask
    endclass

endpackage

>>> verif/hemisphere_partition_min_mass_test.sv
`timescale 1ns / 1ps
// Top of the hemisphere partition testbench: stimulus, handshakes and verdict.
module hemisphere_partition_min_mass_test;
    import hpmm_pkg::*;
    import hpmm_split_pkg::*;

    localparam int TARGET_JETS = 1200;
    localparam int HOLD_CYCLES = 3000;
    localparam int SETTLE      = 100;

    localparam logic signed [MOM_W-1:0] P_MIN = {1'b1, {(MOM_W-1){1'b0}}};
    localparam logic signed [MOM_W-1:0] P_MAX = {1'b0, {(MOM_W-1){1'b1}}};
    localparam logic        [MOM_W-1:0] E_MAX = {MOM_W{1'b1}};

    typedef enum int {
        STYLE_NOISE,
        STYLE_PHYS,
        STYLE_TINY,
        STYLE_EDGE
    } t_jet_style;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic signed [MOM_W-1:0]        i_jet_px;
    logic signed [MOM_W-1:0]        i_jet_py;
    logic signed [MOM_W-1:0]        i_jet_pz;
    logic        [MOM_W-1:0]        i_jet_energy;
    logic                           i_last_jet;
    logic                           o_valid;
    logic                           i_stall;
    logic signed [OUT_W-1:0]        o_lead_px;
    logic signed [OUT_W-1:0]        o_lead_py;
    logic signed [OUT_W-1:0]        o_lead_pz;
    logic        [OUT_W-1:0]        o_lead_energy;
    logic signed [OUT_W-1:0]        o_trail_px;
    logic signed [OUT_W-1:0]        o_trail_py;
    logic signed [OUT_W-1:0]        o_trail_pz;
    logic        [OUT_W-1:0]        o_trail_energy;
    logic        [USED_W-1:0]       o_jets_used;
    logic                           o_jets_dropped;

    split_tracker tracker;
    t_split       seen;
    bit           hold_req;
    int           jets_offered;
    int           burst_left;

    hemisphere_partition_min_mass #(
        .MAX_JETS      (JET_CAP),
        .MOMENTUM_BITS (MOM_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_jet_px       (i_jet_px),
        .i_jet_py       (i_jet_py),
        .i_jet_pz       (i_jet_pz),
        .i_jet_energy   (i_jet_energy),
        .i_last_jet     (i_last_jet),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_lead_px      (o_lead_px),
        .o_lead_py      (o_lead_py),
        .o_lead_pz      (o_lead_pz),
        .o_lead_energy  (o_lead_energy),
        .o_trail_px     (o_trail_px),
        .o_trail_py     (o_trail_py),
        .o_trail_pz     (o_trail_pz),
        .o_trail_energy (o_trail_energy),
        .o_jets_used    (o_jets_used),
        .o_jets_dropped (o_jets_dropped)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAIL hemisphere_partition_min_mass");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            tracker.absorb_jet(i_jet_px, i_jet_py, i_jet_pz, i_jet_energy, i_last_jet);
        if (i_rst_n && o_valid && !i_stall) begin
            seen.comp[COMP_PX]            = o_lead_px;
            seen.comp[COMP_PY]            = o_lead_py;
            seen.comp[COMP_PZ]            = o_lead_pz;
            seen.comp[COMP_E]             = o_lead_energy;
            seen.comp[NUM_COMP + COMP_PX] = o_trail_px;
            seen.comp[NUM_COMP + COMP_PY] = o_trail_py;
            seen.comp[NUM_COMP + COMP_PZ] = o_trail_pz;
            seen.comp[NUM_COMP + COMP_E]  = o_trail_energy;
            seen.used                     = o_jets_used;
            seen.dropped                  = o_jets_dropped;
            tracker.compare_result(seen);
        end
    end

    // Receiver: random stall segments, plus a long hold-off on request.
    initial begin
        int seg, pct;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            seg = $urandom_range(200, 20);
            case ($urandom_range(3))
                0:       pct = 0;
                1:       pct = 25;
                2:       pct = 60;
                default: pct = 90;
            endcase
            repeat (seg) begin
                i_stall <= ($urandom_range(99) < pct);
                @(posedge i_clk);
            end
        end
    end

    function automatic logic signed [MOM_W-1:0] pick_extreme();
        case ($urandom_range(3))
            0:       return P_MIN;
            1:       return P_MAX;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    task automatic make_jet(input t_jet_style style,
                            output logic signed [MOM_W-1:0] px, py, pz,
                            output logic [MOM_W-1:0] e);
        int vx, vy, vz;
        case (style)
            STYLE_NOISE: begin
                px = MOM_W'($urandom);
                py = MOM_W'($urandom);
                pz = MOM_W'($urandom);
                e  = MOM_W'($urandom);
            end
            STYLE_PHYS: begin
                vx = int'($urandom_range(8000)) - 4000;
                vy = int'($urandom_range(8000)) - 4000;
                vz = int'($urandom_range(8000)) - 4000;
                px = MOM_W'(vx);
                py = MOM_W'(vy);
                pz = MOM_W'(vz);
                e  = MOM_W'((vx < 0 ? -vx : vx) + (vy < 0 ? -vy : vy) +
                            (vz < 0 ? -vz : vz) + int'($urandom_range(2000)));
            end
            STYLE_TINY: begin
                vx = int'($urandom_range(6)) - 3;
                vy = int'($urandom_range(6)) - 3;
                vz = int'($urandom_range(6)) - 3;
                px = MOM_W'(vx);
                py = MOM_W'(vy);
                pz = MOM_W'(vz);
                e  = MOM_W'($urandom_range(6));
            end
            default: begin
                px = pick_extreme();
                py = pick_extreme();
                pz = pick_extreme();
                case ($urandom_range(2))
                    0:       e = '0;
                    1:       e = MOM_W'(1);
                    default: e = E_MAX;
                endcase
            end
        endcase
    endtask

    // Offer one jet and hold it until accepted; then continue the burst or idle.
    task automatic offer_jet(input logic signed [MOM_W-1:0] px, py, pz,
                             input logic [MOM_W-1:0] e, input logic last);
        int gap;
        i_jet_px     <= px;
        i_jet_py     <= py;
        i_jet_pz     <= pz;
        i_jet_energy <= e;
        i_last_jet   <= last;
        i_valid      <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        jets_offered++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(30);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_event(input int kept, input int extra, input t_jet_style style);
        logic signed [MOM_W-1:0] px, py, pz;
        logic        [MOM_W-1:0] e;
        t_jet_style              st;
        for (int k = 0; k < kept + extra; k++) begin
            st = ($urandom_range(9) == 0) ? STYLE_NOISE : style;
            make_jet(st, px, py, pz, e);
            offer_jet(px, py, pz, e, k == kept + extra - 1);
        end
    endtask

    task automatic wait_all_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.awaited_splits.size() != 0);
    endtask

    initial begin
        int ev, kept, extra, pick;
        tracker = new();
        hold_req = 1'b0;
        jets_offered = 0;
        burst_left = 0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_jet_px     <= '0;
        i_jet_py     <= '0;
        i_jet_pz     <= '0;
        i_jet_energy <= '0;
        i_last_jet   <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single jet: no split, zero vectors
        offer_jet(P_MIN, P_MAX, P_MIN, E_MAX, 1'b1);
        // opposite extremes
        offer_jet(P_MAX, P_MAX, P_MAX, E_MAX, 1'b0);
        offer_jet(P_MIN, P_MIN, P_MIN, '0, 1'b1);
        // all-zero jets: every split ties, pt ties too
        offer_jet('0, '0, '0, '0, 1'b0);
        offer_jet('0, '0, '0, '0, 1'b1);
        // identical jets: mass ties across splits
        for (int k = 0; k < 3; k++)
            offer_jet(MOM_W'(800), -MOM_W'(800), MOM_W'(300), MOM_W'(2000), k == 2);
        // capacity exceeded, last flag on a dropped jet
        send_event(JET_CAP, 2, STYLE_EDGE);
        wait_all_results();

        ev = 0;
        while (jets_offered < TARGET_JETS) begin
            if (ev == 30 || ev == 200) hold_req = 1'b1;
            if (ev == 120) wait_all_results();
            pick = $urandom_range(99);
            extra = 0;
            if (pick < 2) begin
                kept = JET_CAP;
                extra = ($urandom_range(1) == 0) ? 0 : $urandom_range(3, 1);
            end else if (pick < 10) begin
                kept = $urandom_range(9, 7);
            end else begin
                kept = $urandom_range(6, 1);
            end
            send_event(kept, extra, t_jet_style'($urandom_range(3)));
            ev++;
        end

        wait_all_results();
        repeat (SETTLE) @(posedge i_clk);

        $display("run covered %0d events from %0d jets: %0d over capacity, largest %0d jets",
                 tracker.events, jets_offered, tracker.dropped_events, tracker.largest);
        $display("%0d results compared, %0d mismatches",
                 tracker.results_seen, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("PASS hemisphere_partition_min_mass");
        else
            $display("FAIL hemisphere_partition_min_mass");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/hpmm_pkg.sv
hdl/hpmm_mac.sv
hdl/hemisphere_partition_min_mass.sv
verif/hpmm_split_pkg.sv
verif/hemisphere_partition_min_mass_test.sv
